@@ design/wsl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsl_pkg
// Shared types and constants for the wave-skip link quality monitor.
// ----------------------------------------------------------------------------
package wsl_pkg;

	localparam int WINDOW_LENGTH_DEF = 100;
	localparam int SAMPLE_BITS_DEF   = 11;

	localparam int SAMPLE_W  = 11;   // width of a wave sample port
	localparam int LIMIT_W   = 11;   // width of a step limit register
	localparam int MODE_W    = 3;
	localparam int QUAL_W    = 7;
	localparam int CAP_W     = 11;
	localparam int COUNT_W   = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 11;

	localparam int COUNT_MAX    = 4095;
	localparam int FULL_QUALITY = 100;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MONITOR_MODE = 3'd0,
		REG_LIMIT_GOOD   = 3'd1,
		REG_LIMIT_FAIR   = 3'd2,
		REG_LIMIT_POOR   = 3'd3,
		REG_UPPER_THRESH = 3'd4,
		REG_LOWER_THRESH = 3'd5,
		REG_ESTIMATE_CAP = 3'd6,
		REG_UNUSED       = 3'd7
	} cfg_reg_t;

	// monitor modes
	localparam logic [MODE_W-1:0] MODE_EIGHT_CH   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SIXTEEN_HI = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DUAL_WAVE  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_UPDATE,
		ST_OUT
	} state_t;

	// request from the sequencer to the window store
	typedef struct packed {
		logic               rd_en;
		logic               wr_en;
		logic [COUNT_W-1:0] count;
	} win_req_t;

endpackage

@@ design/wsl_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsl_divider
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wsl_divider #(
	parameter int DVD_W = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DVD_W-1:0]            dividend,
	input  logic [wsl_pkg::LIMIT_W-1:0] divisor,
	output logic                        done,
	output logic [DVD_W-1:0]            quotient
);
	import wsl_pkg::*;

	localparam int REM_W = LIMIT_W + 1;
	localparam int CNT_W = $clog2(DVD_W);

	logic [REM_W-1:0]   rem_q;
	logic [DVD_W-1:0]   quo_q;
	logic [LIMIT_W-1:0] dvs_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [REM_W-1:0]   rem_sh;
	logic               fits;

	assign rem_sh = {rem_q[REM_W-2:0], quo_q[DVD_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift dividend bits in, quotient bits out
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ design/wsl_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsl_window
// Skip-count window memory with running sum and write position.
// ----------------------------------------------------------------------------
module wsl_window #(
	parameter int WINDOW_LENGTH = 100
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wsl_pkg::win_req_t    req,
	output logic [$clog2(WINDOW_LENGTH*wsl_pkg::COUNT_MAX+1)-1:0] sum
);
	import wsl_pkg::*;

	localparam int POS_W = $clog2(WINDOW_LENGTH);
	localparam int SUM_W = $clog2(WINDOW_LENGTH * COUNT_MAX + 1);

	logic [COUNT_W-1:0] mem [WINDOW_LENGTH];
	logic [COUNT_W-1:0] rd_data_q;
	logic [POS_W-1:0]   pos_q;
	logic               full_q;
	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] old_count;

	// entries ahead of the first wrap were never written and count as zero
	assign old_count = full_q ? rd_data_q : '0;

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[pos_q];
		end
		if (req.wr_en) begin
			mem[pos_q] <= req.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			full_q <= 1'b0;
			sum_q  <= '0;
		end else if (req.wr_en) begin
			sum_q <= sum_q - SUM_W'(old_count) + SUM_W'(req.count);
			if (pos_q == POS_W'(WINDOW_LENGTH - 1)) begin
				pos_q  <= '0;
				full_q <= 1'b1;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	assign sum = sum_q;

endmodule

@@ design/wave_skip_link_quality_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wave_skip_link_quality_top
// Link quality estimate from test-wave skips over a sliding frame window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per received
//   frame: both wave samples and the failsafe flag. Output channel
//   (out_valid / out_stall) returns one transaction per frame: quality in
//   percent, the skip count recorded for the frame and the bad-frame flag.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
//   it only while no frame is in flight.
//   From input acceptance the serial divider works one quotient bit per
//   cycle while the window memory read overlaps it; the divide's done step,
//   the window write-back and the output load follow in that order. One
//   frame is in flight at a time and the input opens in the cycle after the
//   output load, so no new frame is taken before the last one has been
//   loaded into the output register.
//   in_stall is high while a frame is in flight. A finished result sits in
//   the output register; while the receiver stalls it, the next frame is
//   still taken and computed, and waits in the final step until the output
//   register frees up.
//   Reset clears the window (through its fill flag), the running sum, the
//   previous samples and the last quality, and loads the register defaults.
// ----------------------------------------------------------------------------
module wave_skip_link_quality_top #(
	parameter int WINDOW_LENGTH = wsl_pkg::WINDOW_LENGTH_DEF,
	parameter int SAMPLE_BITS   = wsl_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [wsl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wsl_pkg::CFG_DAT_W-1:0] cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [wsl_pkg::SAMPLE_W-1:0]  first_wave_sample,
	input  logic [wsl_pkg::SAMPLE_W-1:0]  second_wave_sample,
	input  logic                          failsafe_flag,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [wsl_pkg::QUAL_W-1:0]    quality_percent,
	output logic [wsl_pkg::COUNT_W-1:0]   skipped_count,
	output logic                          bad_frame
);
	import wsl_pkg::*;

	// samples are masked to SAMPLE_BITS; above the port width that is a no-op
	localparam int SMP_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam int CMP_W = (SMP_W > LIMIT_W) ? SMP_W : LIMIT_W;
	localparam int QC_W  = (SMP_W > CAP_W) ? SMP_W : CAP_W;
	localparam int SCL_W = (SMP_W + 1 > COUNT_W) ? SMP_W + 1 : COUNT_W;
	localparam int SUM_W = $clog2(WINDOW_LENGTH * COUNT_MAX + 1);

	// configuration registers
	logic [MODE_W-1:0]  mode_q;
	logic [LIMIT_W-1:0] limit_good_q;
	logic [LIMIT_W-1:0] limit_fair_q;
	logic [LIMIT_W-1:0] limit_poor_q;
	logic [QUAL_W-1:0]  upper_thresh_q;
	logic [QUAL_W-1:0]  lower_thresh_q;
	logic [CAP_W-1:0]   estimate_cap_q;

	// frame state
	state_t             state_q, state_d;
	logic [SMP_W-1:0]   prev_first_q;
	logic [SMP_W-1:0]   prev_second_q;
	logic [QUAL_W-1:0]  last_quality_q;
	logic               failsafe_q;
	logic               bad_q;
	logic [COUNT_W-1:0] count_q;

	// output register
	logic               out_valid_q;
	logic [QUAL_W-1:0]  quality_q;
	logic [COUNT_W-1:0] skipped_q;
	logic               bad_out_q;

	// combinational
	logic               accept_in;
	logic               out_load;
	logic               div_start;
	logic               div_done;
	logic [SMP_W-1:0]   quotient;
	win_req_t           win_req;
	logic [SUM_W-1:0]   win_sum;
	logic [SMP_W-1:0]   cur_smp, prv_smp, step_c;
	logic [LIMIT_W-1:0] limit_sel, limit_c;
	logic               bad_c;
	logic               dbl_c;
	logic [SCL_W-1:0]   scaled_c;
	logic [COUNT_W-1:0] count_c;
	logic [QUAL_W-1:0]  quality_c;

	// ---- configuration writes ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_EIGHT_CH;
			limit_good_q   <= LIMIT_W'(11);
			limit_fair_q   <= LIMIT_W'(9);
			limit_poor_q   <= LIMIT_W'(9);
			upper_thresh_q <= QUAL_W'(75);
			lower_thresh_q <= QUAL_W'(50);
			estimate_cap_q <= CAP_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MONITOR_MODE: mode_q         <= cfg_data[MODE_W-1:0];
				REG_LIMIT_GOOD:   limit_good_q   <= cfg_data[LIMIT_W-1:0];
				REG_LIMIT_FAIR:   limit_fair_q   <= cfg_data[LIMIT_W-1:0];
				REG_LIMIT_POOR:   limit_poor_q   <= cfg_data[LIMIT_W-1:0];
				REG_UPPER_THRESH: upper_thresh_q <= cfg_data[QUAL_W-1:0];
				REG_LOWER_THRESH: lower_thresh_q <= cfg_data[QUAL_W-1:0];
				REG_ESTIMATE_CAP: estimate_cap_q <= cfg_data[CAP_W-1:0];
				REG_UNUSED:       ;
				default:          ;
			endcase
		end
	end

	// ---- step and limit, evaluated on the accepting edge ----
	always_comb begin
		// modes from sixteen-high-wave upward watch the second wave
		if (mode_q >= MODE_SIXTEEN_HI) begin
			cur_smp = second_wave_sample[SMP_W-1:0];
			prv_smp = prev_second_q;
		end else begin
			cur_smp = first_wave_sample[SMP_W-1:0];
			prv_smp = prev_first_q;
		end
		step_c = (cur_smp >= prv_smp) ? (cur_smp - prv_smp) : (prv_smp - cur_smp);

		// poor only when below both thresholds
		priority if (last_quality_q >= upper_thresh_q)
			limit_sel = limit_good_q;
		else if (last_quality_q >= lower_thresh_q)
			limit_sel = limit_fair_q;
		else
			limit_sel = limit_poor_q;

		// a zero limit acts as one
		limit_c = (limit_sel == '0) ? LIMIT_W'(1) : limit_sel;
		bad_c   = CMP_W'(step_c) > CMP_W'(limit_c);
	end

	// ---- skip count from the quotient ----
	always_comb begin
		// single-wave sixteen-channel modes double small counts
		dbl_c = (mode_q != MODE_EIGHT_CH) && (mode_q != MODE_DUAL_WAVE) &&
			(QC_W'(quotient) < QC_W'(estimate_cap_q));
		scaled_c = dbl_c ? (SCL_W'(quotient) << 1) : SCL_W'(quotient);
		priority if (failsafe_q)
			count_c = COUNT_W'(1);
		else if (!bad_q)
			count_c = '0;
		else if (scaled_c > SCL_W'(COUNT_MAX))
			count_c = COUNT_W'(COUNT_MAX);
		else
			count_c = scaled_c[COUNT_W-1:0];
	end

	// quality from the updated window sum, floored at zero
	assign quality_c = (win_sum > SUM_W'(FULL_QUALITY)) ? '0 :
		QUAL_W'(FULL_QUALITY) - win_sum[QUAL_W-1:0];

	// ---- sequencer ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept_in) state_d = ST_DIV;
			ST_DIV:    if (div_done) state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_OUT;
			ST_OUT:    if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		accept_in     = in_valid && (state_q == ST_IDLE);
		in_stall      = (state_q != ST_IDLE);
		div_start     = accept_in;
		win_req.rd_en = accept_in;
		win_req.wr_en = (state_q == ST_UPDATE);
		win_req.count = count_c;
		out_load      = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			prev_first_q   <= '0;
			prev_second_q  <= '0;
			last_quality_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept_in) begin
				prev_first_q  <= first_wave_sample[SMP_W-1:0];
				prev_second_q <= second_wave_sample[SMP_W-1:0];
			end
			if (out_load) begin
				last_quality_q <= quality_c;
			end
		end
	end

	// hold the frame's operands for the divide and the count
	always_ff @(posedge clk) begin
		if (accept_in) begin
			failsafe_q <= failsafe_flag;
			bad_q      <= bad_c;
		end
		if (state_q == ST_UPDATE) begin
			count_q <= count_c;
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			quality_q <= quality_c;
			skipped_q <= count_q;
			bad_out_q <= bad_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign quality_percent = quality_q;
	assign skipped_count   = skipped_q;
	assign bad_frame       = bad_out_q;

	// ---- submodules ----
	wsl_divider #(
		.DVD_W    (SMP_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (step_c),
		.divisor  (limit_c),
		.done     (div_done),
		.quotient (quotient)
	);

	wsl_window #(
		.WINDOW_LENGTH (WINDOW_LENGTH)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (win_req),
		.sum    (win_sum)
	);

	// ---- assertions ----
	// a result only appears from the final step of a frame
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("out_valid rose outside the output step");

	// one frame in flight: an accepted transaction blocks the next cycle
	a_single_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a frame is in flight");

	// quality stays within percent range
	a_quality_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (quality_percent <= QUAL_W'(FULL_QUALITY)))
		else $error("quality above full scale");

	// the window is written only after the divide has finished
	a_write_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		win_req.wr_en |-> $past(div_done))
		else $error("window written without a finished divide");

endmodule
